### hdl/dlp_pkg.sv
`default_nettype none

package dlp_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int FRAC_BITS_DEF  = 8;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // latch a new request and set up the divider
      logic div_step;  // one quotient bit of the minor step
      logic pt_step;   // advance to the next point
   } dlp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic zero_len;  // request on the port has start equal to end
      logic div_last;  // this divider step produces the final quotient bit
      logic run_last;  // current point is the last of the run
   } dlp_sts_type;

endpackage

`default_nettype wire

### hdl/dlp_req_if.sv
`default_nettype none

interface dlp_req_if #(
   parameter int COORD_BITS = dlp_pkg::COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (
      output valid, start_x, start_y, end_x, end_y,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, end_x, end_y,
      output ready
   );
endinterface

`default_nettype wire

### hdl/dlp_rsp_if.sv
`default_nettype none

interface dlp_rsp_if #(
   parameter int COORD_BITS = dlp_pkg::COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic                  last_point;

   modport source (
      output valid, point_x, point_y, last_point,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, last_point,
      output ready
   );
endinterface

`default_nettype wire

### hdl/dda_line_points_core.sv
// channel   dir  signals                                    meaning
// req_chan  in   valid ready start_x start_y end_x end_y    line request
// rsp_chan  out  valid ready point_x point_y last_point     one point of the run
//
// A request is taken only when the core is idle. The minor step comes from a
// restoring divider, one quotient bit per cycle: an integer bit and FRAC_BITS
// fraction bits. Then one point per cycle while rsp_chan.ready is high,
// max(|dx|,|dy|) points in all. A zero-length request is taken but gives no
// point. Reset only returns the controller to idle and drops a run in progress.
`default_nettype none

module dda_line_points_core #(
   parameter int COORD_BITS = dlp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlp_pkg::FRAC_BITS_DEF
) (
   input wire          clock,
   input wire          reset,
   dlp_req_if.sink     req_chan,
   dlp_rsp_if.source   rsp_chan
);

   dlp_pkg::dlp_cmd_type cmd;
   dlp_pkg::dlp_sts_type sts;

   dlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dlp_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .sts        (sts),
      .start_x    (req_chan.start_x),
      .start_y    (req_chan.start_y),
      .end_x      (req_chan.end_x),
      .end_y      (req_chan.end_y),
      .point_x    (rsp_chan.point_x),
      .point_y    (rsp_chan.point_y),
      .last_point (rsp_chan.last_point)
   );

endmodule

`default_nettype wire

### hdl/dlp_datapath.sv
`default_nettype none

module dlp_datapath #(
   parameter int COORD_BITS = dlp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlp_pkg::FRAC_BITS_DEF
) (
   input  wire                         clock,
   input  wire  dlp_pkg::dlp_cmd_type  cmd,
   output dlp_pkg::dlp_sts_type        sts,
   input  wire  [COORD_BITS-1:0]       start_x,
   input  wire  [COORD_BITS-1:0]       start_y,
   input  wire  [COORD_BITS-1:0]       end_x,
   input  wire  [COORD_BITS-1:0]       end_y,
   output logic [COORD_BITS-1:0]       point_x,
   output logic [COORD_BITS-1:0]       point_y,
   output logic                        last_point
);

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS;
   localparam int STEP_BITS = FRAC_BITS + 1;
   localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);

   logic [COORD_BITS-1:0] adx, ady, amaj, amin, maj0, min0;
   logic                  x_major, maj_up, min_up;

   logic                  xmaj_ff, xmaj_in;
   logic                  majup_ff, majup_in;
   logic                  minup_ff, minup_in;
   logic [COORD_BITS-1:0] amaj_ff, amaj_in;
   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] maj_ff, maj_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [COORD_BITS-1:0] left_ff, left_in;

   logic                  rem_ge;
   logic [COORD_BITS:0]   rem_diff;
   logic [ACC_BITS-1:0]   step_ext;

   // request decode, used only on the load cycle
   always_comb begin
      adx     = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
      ady     = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
      x_major = (adx >= ady);
      amaj    = x_major ? adx : ady;
      amin    = x_major ? ady : adx;
      maj0    = x_major ? start_x : start_y;
      min0    = x_major ? start_y : start_x;
      maj_up  = x_major ? (end_x >= start_x) : (end_y >= start_y);
      min_up  = x_major ? (end_y >= start_y) : (end_x >= start_x);
   end

   // restoring divider: remainder starts at amin, at most amaj, so the first compare
   // gives the integer bit of the step and each later one a fraction bit
   assign rem_ge   = (rem_ff >= {1'b0, amaj_ff});
   assign rem_diff = rem_ge ? (rem_ff - {1'b0, amaj_ff}) : rem_ff;
   assign step_ext = ACC_BITS'(step_ff);

   always_comb begin
      xmaj_in  = xmaj_ff;
      majup_in = majup_ff;
      minup_in = minup_ff;
      amaj_in  = amaj_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      maj_in   = maj_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      if (cmd.load) begin
         xmaj_in  = x_major;
         majup_in = maj_up;
         minup_in = min_up;
         amaj_in  = amaj;
         rem_in   = {1'b0, amin};
         step_in  = '0;
         cnt_in   = '0;
         maj_in   = maj0;
         acc_in   = {min0, {FRAC_BITS{1'b0}}};
         left_in  = amaj;
      end else if (cmd.div_step) begin
         rem_in  = {rem_diff[COORD_BITS-1:0], 1'b0};
         step_in = {step_ff[STEP_BITS-2:0], rem_ge};
         cnt_in  = cnt_ff + 1'b1;
      end else if (cmd.pt_step) begin
         acc_in  = minup_ff ? (acc_ff + step_ext) : (acc_ff - step_ext);
         maj_in  = majup_ff ? (maj_ff + 1'b1) : (maj_ff - 1'b1);
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      xmaj_ff  <= xmaj_in;
      majup_ff <= majup_in;
      minup_ff <= minup_in;
      amaj_ff  <= amaj_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      maj_ff   <= maj_in;
      acc_ff   <= acc_in;
      left_ff  <= left_in;
   end

   assign sts.zero_len = (start_x == end_x) && (start_y == end_y);
   assign sts.div_last = (cnt_ff == CNT_BITS'(FRAC_BITS));
   assign sts.run_last = (left_ff == COORD_BITS'(1));

   assign point_x    = xmaj_ff ? maj_ff : acc_ff[ACC_BITS-1:FRAC_BITS];
   assign point_y    = xmaj_ff ? acc_ff[ACC_BITS-1:FRAC_BITS] : maj_ff;
   assign last_point = sts.run_last;

endmodule

`default_nettype wire

### hdl/dlp_ctrl.sv
`default_nettype none

module dlp_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output dlp_pkg::dlp_cmd_type  cmd,
   input  wire  dlp_pkg::dlp_sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load     = req_valid && req_ready;
   assign cmd.div_step = (state_ff == ST_DIVIDE);
   assign cmd.pt_step  = (state_ff == ST_EMIT) && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               // a zero-length request is taken and dropped
               if (req_valid && !sts.zero_len) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (sts.div_last) begin
                  state_ff     <= ST_EMIT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (rsp_ready && sts.run_last) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### dv/dda_line_points_core_tb.sv
`timescale 1ns / 1ps

typedef logic [dlp_pkg::COORD_BITS_DEF-1:0] coord_type;

typedef struct packed {
   coord_type sx;
   coord_type sy;
   coord_type ex;
   coord_type ey;
} line_type;

typedef struct packed {
   coord_type x;
   coord_type y;
   logic      last;
} point_type;

class point_ledger;
   localparam int CB = dlp_pkg::COORD_BITS_DEF;
   localparam int FB = dlp_pkg::FRAC_BITS_DEF;

   point_type   due_points[$];
   int unsigned failures;
   int unsigned lines_taken;
   int unsigned zero_lines;
   int unsigned points_seen;
   int unsigned longest_run;

   // expand one accepted request into the points the core should emit
   function void add_line(line_type l);
      coord_type       adx, ady, amaj, amin, maj0, min0, mj, mn;
      logic [CB+FB:0]  step, acc, base;
      bit              xmaj, maj_up, min_up;
      point_type       p;
      lines_taken++;
      adx    = (l.ex >= l.sx) ? coord_type'(l.ex - l.sx) : coord_type'(l.sx - l.ex);
      ady    = (l.ey >= l.sy) ? coord_type'(l.ey - l.sy) : coord_type'(l.sy - l.ey);
      xmaj   = (adx >= ady);
      amaj   = xmaj ? adx : ady;
      amin   = xmaj ? ady : adx;
      maj0   = xmaj ? l.sx : l.sy;
      min0   = xmaj ? l.sy : l.sx;
      maj_up = xmaj ? (l.ex >= l.sx) : (l.ey >= l.sy);
      min_up = xmaj ? (l.ey >= l.sy) : (l.ex >= l.sx);
      if (amaj == 0) begin
         zero_lines++;
         return;
      end
      if (amaj > longest_run) longest_run = amaj;
      step = ((CB+FB+1)'(amin) << FB) / amaj;
      base = (CB+FB+1)'(min0) << FB;
      for (int k = 0; k < amaj; k++) begin
         acc = min_up ? base + (CB+FB+1)'(k) * step : base - (CB+FB+1)'(k) * step;
         mn  = acc[FB +: CB];
         mj  = maj_up ? coord_type'(maj0 + k) : coord_type'(maj0 - k);
         p.x    = xmaj ? mj : mn;
         p.y    = xmaj ? mn : mj;
         p.last = (k + 1 == amaj);
         due_points = {due_points, p};
      end
   endfunction

   function void match_point(point_type got);
      point_type want;
      points_seen++;
      if (due_points.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected point x=%0d y=%0d last=%0d", got.x, got.y, got.last);
         return;
      end
      want = due_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
         failures++;
         if (failures <= 10)
            $display("point mismatch: expected x=%0d y=%0d last=%0d, %s",
                     want.x, want.y, want.last,
                     $sformatf("got x=%0d y=%0d last=%0d", got.x, got.y, got.last));
      end
   endfunction
endclass

module dda_line_points_core_tb;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_LINES = 250;

   typedef enum int {RX_FULL, RX_MOSTLY, RX_SPARSE, RX_SQUARE} rx_mode_type;

   logic clock;
   logic reset;

   dlp_req_if req_chan ();
   dlp_rsp_if rsp_chan ();

   dda_line_points_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   point_ledger ledger = new();

   int unsigned cycle_count;
   int unsigned hold_ask;
   int          burst_left;
   bit          no_gap;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d points outstanding",
                  cycle_count, ledger.due_points.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stall patterns, plus a long hold-off on request
   initial begin
      int unsigned hold_seen;
      int unsigned hold_left;
      int          mode_left;
      rx_mode_type mode;
      point_type   got;
      hold_seen = 0;
      hold_left = 0;
      mode_left = 0;
      mode = RX_FULL;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.x    = rsp_chan.point_x;
            got.y    = rsp_chan.point_y;
            got.last = rsp_chan.last_point;
            ledger.match_point(got);
         end
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               RX_FULL:   rsp_chan.ready <= 1'b1;
               RX_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_chan.ready <= ((cycle_count / 5) % 2 == 0);
            endcase
         end
      end
   end

   task automatic offer_line(line_type l);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = no_gap ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= l.sx;
      req_chan.start_y <= l.sy;
      req_chan.end_x   <= l.ex;
      req_chan.end_y   <= l.ey;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      ledger.add_line(l);
   endtask

   task automatic drain_points();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (ledger.due_points.size() != 0);
   endtask

   function automatic coord_type near_coord(coord_type c);
      int lo, hi;
      lo = (c > 8) ? c - 8 : 0;
      hi = (c < 55) ? c + 8 : 63;
      return coord_type'($urandom_range(lo, hi));
   endfunction

   function automatic line_type random_line();
      line_type  l;
      int        pick;
      int        d;
      coord_type t;
      pick = $urandom_range(0, 99);
      l.sx = coord_type'($urandom_range(0, 63));
      l.sy = coord_type'($urandom_range(0, 63));
      if (pick < 55) begin
         l.ex = near_coord(l.sx);
         l.ey = near_coord(l.sy);
      end else if (pick < 80) begin
         l.ex = coord_type'($urandom_range(0, 63));
         l.ey = coord_type'($urandom_range(0, 63));
      end else if (pick < 88) begin
         // diagonal in a random direction
         l.ex = coord_type'($urandom_range(0, 63));
         d    = (l.ex >= l.sx) ? l.ex - l.sx : l.sx - l.ex;
         l.sy = coord_type'($urandom_range(0, 63 - d));
         l.ey = coord_type'(l.sy + d);
         if ($urandom_range(0, 1)) begin
            t = l.sy; l.sy = l.ey; l.ey = t;
         end
      end else if (pick < 94) begin
         l.ex = $urandom_range(0, 1) ? l.sx : coord_type'($urandom_range(0, 63));
         l.ey = (l.ex == l.sx) ? coord_type'($urandom_range(0, 63)) : l.sy;
      end else begin
         l.ex = l.sx;
         l.ey = l.sy;
      end
      return l;
   endfunction

   initial begin
      line_type directed[$];
      line_type l;
      int       n_lines;
      bit       drained;
      directed = '{
         line_type'{6'd0,  6'd0,  6'd0,  6'd0},     // zero length
         line_type'{6'd63, 6'd63, 6'd63, 6'd63},    // zero length at the top corner
         line_type'{6'd0,  6'd0,  6'd63, 6'd63},    // full diagonals, all four directions
         line_type'{6'd63, 6'd63, 6'd0,  6'd0},
         line_type'{6'd0,  6'd63, 6'd63, 6'd0},
         line_type'{6'd63, 6'd0,  6'd0,  6'd63},
         line_type'{6'd0,  6'd5,  6'd63, 6'd5},     // horizontal
         line_type'{6'd63, 6'd58, 6'd0,  6'd58},
         line_type'{6'd7,  6'd0,  6'd7,  6'd63},    // vertical
         line_type'{6'd42, 6'd63, 6'd42, 6'd0},
         line_type'{6'd0,  6'd10, 6'd63, 6'd13},    // shallow, minor up
         line_type'{6'd63, 6'd50, 6'd0,  6'd20},    // shallow, minor down
         line_type'{6'd10, 6'd0,  6'd13, 6'd63},    // steep, minor up
         line_type'{6'd60, 6'd63, 6'd1,  6'd0},     // steep, minor down, near diagonal
         line_type'{6'd5,  6'd5,  6'd6,  6'd5},     // single points
         line_type'{6'd5,  6'd5,  6'd5,  6'd4},
         line_type'{6'd0,  6'd0,  6'd1,  6'd1},
         line_type'{6'd0,  6'd0,  6'd63, 6'd62},    // one short of diagonal
         line_type'{6'd0,  6'd0,  6'd62, 6'd63},
         line_type'{6'd21, 6'd42, 6'd42, 6'd21},
         line_type'{6'd63, 6'd0,  6'd0,  6'd1}
      };
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.start_x <= '0;
      req_chan.start_y <= '0;
      req_chan.end_x   <= '0;
      req_chan.end_y   <= '0;
      hold_ask         <= 0;
      burst_left = 0;
      no_gap     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) offer_line(directed[i]);

      // long output hold-off while requests keep coming back to back
      hold_ask <= hold_ask + 1;
      no_gap = 1'b1;
      repeat (20) offer_line(random_line());
      no_gap = 1'b0;

      n_lines = 0;
      drained = 1'b0;
      while (n_lines < RANDOM_LINES) begin
         if (n_lines == RANDOM_LINES / 2 && !drained) begin
            drain_points();
            drained = 1'b1;
         end
         no_gap = (n_lines >= 200 && n_lines < 240);
         l = random_line();
         offer_line(l);
         if (l.sx != l.ex || l.sy != l.ey) n_lines++;
      end

      drain_points();
      repeat (40) @(posedge clock);

      $display("covered %0d line requests (%0d of zero length), %0d points, longest run %0d",
               ledger.lines_taken, ledger.zero_lines, ledger.points_seen, ledger.longest_run);
      if (ledger.due_points.size() != 0) begin
         $display("%0d expected points never arrived", ledger.due_points.size());
         ledger.failures++;
      end
      $display("%0d mismatches or stray points", ledger.failures);
      if (ledger.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
hdl/dlp_pkg.sv
hdl/dlp_req_if.sv
hdl/dlp_rsp_if.sv
hdl/dlp_datapath.sv
hdl/dlp_ctrl.sv
hdl/dda_line_points_core.sv
dv/dda_line_points_core_tb.sv
